// File: sv/rgb2lab_pkg.sv
// ----------------------------------------------------------------------------
// rgb2lab_pkg
// Shared types, constants and constant tables of the sRGB to CIELAB (D65)
// converter: gamma ROM contents, RGB-to-XYZ matrix, white point divisors and
// output formatting constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgb2lab_pkg;

  // Datapath widths
  localparam int CODE_W  = 8;   // sRGB code
  localparam int LIN_W   = 17;  // linear channel, Q16, up to 1.0
  localparam int COEF_W  = 20;  // matrix coefficient, scaled by 1e6
  localparam int SUM_W   = 37;  // matrix row sum
  localparam int V_W     = 16;  // cube-root ROM entry, Q16
  localparam int LAB_W   = 27;  // signed Lab value, Q16
  localparam int L_OUT_W = 15;
  localparam int AB_OUT_W = 16;

  // Output formatting: round Q16 down to OUT_FRAC_BITS, ties toward +inf
  localparam int OUT_FRAC_BITS = 8;
  localparam int RND_SHIFT     = 16 - OUT_FRAC_BITS;
  localparam int RND_HALF      = 1 << (RND_SHIFT - 1);

  // Lab formation and clamping (Q16)
  localparam int L_SCALE  = 116;
  localparam int A_SCALE  = 500;
  localparam int B_SCALE  = 200;
  localparam int L_OFFSET = 16 << 16;
  localparam int L_MAX    = 100 << 16;
  localparam int AB_MAX   = 120 << 16;

  // Fraction bits of the reciprocal used for the index quotient
  localparam int RECIP_SHIFT = 48;

  // D65 RGB-to-XYZ matrix, rows X, Y, Z and columns R, G, B, scaled by 1e6
  localparam logic [COEF_W-1:0] MAT_COEF [3][3] = '{
    '{20'd412453, 20'd357580, 20'd180423},
    '{20'd212671, 20'd715160, 20'd72169},
    '{20'd19334,  20'd119193, 20'd950227}
  };

  // Row sum that maps to an index of one full table depth (white point, Q16)
  localparam logic [63:0] XYZ_DIV [3] = '{
    64'd655360 * 64'd95047,
    64'd65536000000,
    64'd655360 * 64'd108883
  };

  // Gamma ROM build
  localparam logic [63:0] GAMMA_DEN = 64'd269025 * 64'd269025;

  typedef logic [LIN_W-1:0] gamma_rom_t [256];

  // One linearized code in Q16: linear segment below the knee, else t^2.4
  function automatic logic [LIN_W-1:0] gamma_entry(input logic [CODE_W-1:0] code);
    logic [63:0] n;
    logic [63:0] u;
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p;
    logic [63:0] e;
    n = 64'd0;
    u = 64'd0;
    target = 64'd0;
    lo = 64'd0;
    hi = 64'd4096;
    mid = 64'd0;
    p = 64'd0;
    if (code <= 8'd10) begin
      e = (64'(code) * 64'd6553600 + 64'd164730) / 64'd329460;
    end else begin
      n = 64'd1000 * 64'(code) + 64'd14025;
      u = ((n * n) << 24) / GAMMA_DEN;
      target = u << 36;
      // fifth root in Q12 by bisection
      for (int i = 0; i < 14; i++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          p = mid * mid * mid * mid * mid;
          if (p <= target) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      e = (u * lo + (64'd1 << 19)) >> 20;
    end
    return e[LIN_W-1:0];
  endfunction

  function automatic gamma_rom_t gamma_table();
    gamma_rom_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = gamma_entry(CODE_W'(i));
    end
    return t;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = gamma_table();

endpackage

`default_nettype wire

// File: sv/rgb_to_cielab_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_to_cielab_converter_core
// Pixel-stream sRGB to CIELAB (D65) converter with fixed-point Lab output.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                Payload
//  -------  ---------  -----------------------  ------------------------------
//  in       input      in_valid_i / in_stall_o  red_i, green_i, blue_i
//  out      output     out_valid_o / out_stall_i lightness_o, green_red_axis_o,
//                                               blue_yellow_axis_o
//
//  One pixel per clock while the output side is not stalled.
//  The depth is set by the cube-root ROM read and the quotient correction,
//  each of which sits between registers of its own.
//  Reset clears only the stage valid bits; the ROMs are constant.
//  Each stage holds while the stage after it is full and held, so bubbles
//  close up under a stall and no transfer is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_cielab_converter_core #(
  parameter int CUBE_TABLE_DEPTH = 4000
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          red_i,
  input  wire logic [7:0]          green_i,
  input  wire logic [7:0]          blue_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [14:0]              lightness_o,
  output logic signed [15:0]       green_red_axis_o,
  output logic signed [15:0]       blue_yellow_axis_o
);

  localparam int NUM_STAGES = 8;
  localparam int IDX_W      = $clog2(CUBE_TABLE_DEPTH);
  localparam int Q_W        = IDX_W + 1;
  localparam int CMP_W      = rgb2lab_pkg::SUM_W + Q_W;
  localparam int V_W        = rgb2lab_pkg::V_W;
  localparam int LAB_W      = rgb2lab_pkg::LAB_W;
  localparam int SUM_W      = rgb2lab_pkg::SUM_W;
  localparam int LIN_W      = rgb2lab_pkg::LIN_W;

  // Reciprocals of the white point divisors, scaled by depth * 2^RECIP_SHIFT
  localparam logic [63:0] RECIP [3] = '{
    (64'(CUBE_TABLE_DEPTH) << rgb2lab_pkg::RECIP_SHIFT) / rgb2lab_pkg::XYZ_DIV[0],
    (64'(CUBE_TABLE_DEPTH) << rgb2lab_pkg::RECIP_SHIFT) / rgb2lab_pkg::XYZ_DIV[1],
    (64'(CUBE_TABLE_DEPTH) << rgb2lab_pkg::RECIP_SHIFT) / rgb2lab_pkg::XYZ_DIV[2]
  };
  // X has the smallest divisor, so its reciprocal is the widest
  localparam int M_W    = $clog2(RECIP[0] + 64'd1);
  localparam int PROD_W = SUM_W + M_W;

  localparam logic [63:0] CUBE_LIN_DEN = 64'd29000 * 64'(CUBE_TABLE_DEPTH);
  localparam logic [63:0] CUBE_KNEE    = 64'd8856 * 64'(CUBE_TABLE_DEPTH);

  // --------------------------------------------------------------------------
  // Cube-root ROM contents
  // --------------------------------------------------------------------------
  typedef logic [V_W-1:0] cube_rom_t [CUBE_TABLE_DEPTH];

  // f^(1/3) in Q16 above the knee, linear segment 7.787 f + 16/116 below
  function automatic logic [V_W-1:0] cube_entry(input logic [IDX_W-1:0] k);
    logic [63:0] kk;
    logic [63:0] target;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] e;
    kk = 64'(k);
    target = 64'd0;
    lo = 64'd0;
    hi = 64'd65536;
    mid = 64'd0;
    if (kk * 64'd1000000 > CUBE_KNEE) begin
      target = (kk << 48) / CUBE_TABLE_DEPTH;
      for (int i = 0; i < 18; i++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (mid * mid * mid <= target) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      e = lo;
    end else begin
      e = ((64'd225823 * kk + 64'd4000 * 64'(CUBE_TABLE_DEPTH)) * 64'd65536)
          / CUBE_LIN_DEN;
    end
    return e[V_W-1:0];
  endfunction

  function automatic cube_rom_t cube_table();
    cube_rom_t t;
    for (int k = 0; k < CUBE_TABLE_DEPTH; k++) begin
      t[k] = cube_entry(IDX_W'(k));
    end
    return t;
  endfunction

  localparam cube_rom_t CUBE_ROM = cube_table();

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its content moves on
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_q, vld_d;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !out_stall_i;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (adv[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (adv[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];

  // --------------------------------------------------------------------------
  // Stage 0: gamma linearization
  // --------------------------------------------------------------------------
  logic [LIN_W-1:0] lin_q [3];
  logic [LIN_W-1:0] lin_d [3];

  always_comb begin
    lin_d[0] = rgb2lab_pkg::GAMMA_ROM[red_i];
    lin_d[1] = rgb2lab_pkg::GAMMA_ROM[green_i];
    lin_d[2] = rgb2lab_pkg::GAMMA_ROM[blue_i];
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      lin_q <= lin_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: matrix products, row = X/Y/Z, column = R/G/B
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] prod_q [3][3];
  logic [SUM_W-1:0] prod_d [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = SUM_W'(lin_q[c]) * SUM_W'(rgb2lab_pkg::MAT_COEF[r][c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      prod_q <= prod_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: row sums
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_q [3];
  logic [SUM_W-1:0] sum_d [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = prod_q[r][0] + prod_q[r][1] + prod_q[r][2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      sum_q <= sum_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: quotient estimate by reciprocal, low by at most one
  // --------------------------------------------------------------------------
  logic [Q_W-1:0]    quot_q [3];
  logic [Q_W-1:0]    quot_d [3];
  logic [SUM_W-1:0]  sum3_q [3];
  logic [PROD_W-1:0] recip_prod [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      recip_prod[r] = PROD_W'(sum_q[r]) * PROD_W'(RECIP[r][M_W-1:0]);
      quot_d[r]     = Q_W'(recip_prod[r] >> rgb2lab_pkg::RECIP_SHIFT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      quot_q <= quot_d;
      sum3_q <= sum_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: exact floor by one compare, then saturate to the last entry
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0] idx_q [3];
  logic [IDX_W-1:0] idx_d [3];
  logic [Q_W-1:0]   quot_inc [3];
  logic [Q_W-1:0]   quot_fix [3];
  logic [CMP_W-1:0] cmp_lhs [3];
  logic [CMP_W-1:0] cmp_rhs [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      quot_inc[r] = quot_q[r] + Q_W'(1);
      cmp_lhs[r]  = CMP_W'(sum3_q[r]) * CMP_W'(CUBE_TABLE_DEPTH);
      cmp_rhs[r]  = CMP_W'(quot_inc[r]) * CMP_W'(rgb2lab_pkg::XYZ_DIV[r]);
      quot_fix[r] = (cmp_lhs[r] >= cmp_rhs[r]) ? quot_inc[r] : quot_q[r];
      if (quot_fix[r] >= Q_W'(CUBE_TABLE_DEPTH)) begin
        idx_d[r] = IDX_W'(CUBE_TABLE_DEPTH - 1);
      end else begin
        idx_d[r] = quot_fix[r][IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      idx_q <= idx_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: cube-root ROM, registered read
  // --------------------------------------------------------------------------
  logic [V_W-1:0] cv_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      for (int r = 0; r < 3; r++) begin
        cv_q[r] <= CUBE_ROM[idx_q[r]];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: L*, a*, b* in Q16
  // --------------------------------------------------------------------------
  logic signed [LAB_W-1:0] vx, vy, vz;
  logic signed [LAB_W-1:0] l_q, a_q, b_q;
  logic signed [LAB_W-1:0] l_d, a_d, b_d;

  always_comb begin
    vx  = LAB_W'($signed({1'b0, cv_q[0]}));
    vy  = LAB_W'($signed({1'b0, cv_q[1]}));
    vz  = LAB_W'($signed({1'b0, cv_q[2]}));
    l_d = vy * LAB_W'(rgb2lab_pkg::L_SCALE) - LAB_W'(rgb2lab_pkg::L_OFFSET);
    a_d = (vx - vy) * LAB_W'(rgb2lab_pkg::A_SCALE);
    b_d = (vy - vz) * LAB_W'(rgb2lab_pkg::B_SCALE);
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      l_q <= l_d;
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: clamp, round to the output format, output register
  // --------------------------------------------------------------------------
  localparam logic signed [LAB_W-1:0] L_LO  = '0;
  localparam logic signed [LAB_W-1:0] L_HI  = LAB_W'(rgb2lab_pkg::L_MAX);
  localparam logic signed [LAB_W-1:0] AB_HI = LAB_W'(rgb2lab_pkg::AB_MAX);
  localparam logic signed [LAB_W-1:0] AB_LO = -AB_HI;
  localparam logic signed [LAB_W-1:0] HALF  = LAB_W'(rgb2lab_pkg::RND_HALF);

  logic signed [LAB_W-1:0] l_clip, a_clip, b_clip;
  logic signed [LAB_W-1:0] l_rnd, a_rnd, b_rnd;
  logic [14:0]             lightness_q, lightness_d;
  logic signed [15:0]      gr_axis_q, gr_axis_d;
  logic signed [15:0]      by_axis_q, by_axis_d;

  always_comb begin
    priority if (l_q < L_LO) begin
      l_clip = L_LO;
    end else if (l_q > L_HI) begin
      l_clip = L_HI;
    end else begin
      l_clip = l_q;
    end

    priority if (a_q < AB_LO) begin
      a_clip = AB_LO;
    end else if (a_q > AB_HI) begin
      a_clip = AB_HI;
    end else begin
      a_clip = a_q;
    end

    priority if (b_q < AB_LO) begin
      b_clip = AB_LO;
    end else if (b_q > AB_HI) begin
      b_clip = AB_HI;
    end else begin
      b_clip = b_q;
    end

    // floor(v + half): ties go toward +inf for either sign
    l_rnd = (l_clip + HALF) >>> rgb2lab_pkg::RND_SHIFT;
    a_rnd = (a_clip + HALF) >>> rgb2lab_pkg::RND_SHIFT;
    b_rnd = (b_clip + HALF) >>> rgb2lab_pkg::RND_SHIFT;

    lightness_d = l_rnd[rgb2lab_pkg::L_OUT_W-1:0];
    gr_axis_d   = a_rnd[rgb2lab_pkg::AB_OUT_W-1:0];
    by_axis_d   = b_rnd[rgb2lab_pkg::AB_OUT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      lightness_q <= lightness_d;
      gr_axis_q   <= gr_axis_d;
      by_axis_q   <= by_axis_d;
    end
  end

  assign lightness_o        = lightness_q;
  assign green_red_axis_o   = gr_axis_q;
  assign blue_yellow_axis_o = by_axis_q;

endmodule

`default_nettype wire

// File: tb/rgb_to_cielab_converter_core_test.sv
// ----------------------------------------------------------------------------
// rgb_to_cielab_converter_core_test
// Self-checking bench for the sRGB to CIELAB (D65) pixel converter. A short
// table of corner pixels is followed by about 1200 random pixels. Every
// accepted pixel without a typed-in golden result is run through a bit-exact
// fixed-point model kept here (gamma ROM, D65 matrix, cube-root ROM, clamp and
// round), and every output transfer is checked field by field against the
// oldest pending result. Input bursts, output stall patterns and one long
// output hold-off vary the pipeline occupancy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_cielab_converter_core_test;

  localparam int CUBE_DEPTH      = 4000;
  localparam int N_RANDOM        = 1200;
  localparam int HOLD_OFF_AT     = 400;   // pixels accepted before the long hold-off
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES    = 16;    // pipeline is 8 deep

  // Fixed-point constants of the conversion (Q16 where not noted)
  localparam longint unsigned X_DIV = 64'd655360 * 64'd95047;
  localparam longint unsigned Y_DIV = 64'd65536000000;
  localparam longint unsigned Z_DIV = 64'd655360 * 64'd108883;
  localparam longint LQ_MAX  = 100 * 65536;
  localparam longint ABQ_MAX = 120 * 65536;

  typedef struct packed {
    logic        [14:0] l_star;
    logic signed [15:0] a_star;
    logic signed [15:0] b_star;
  } lab_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       known;    // golden result typed in below
    lab_t       golden;
  } pixel_row_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  localparam lab_t LAB_BLACK = '0;

  // Corner pixels: black, white, primaries, secondaries, gamma knee, bit patterns
  localparam int N_DIRECTED = 23;
  localparam pixel_row_t CORNER_TBL [N_DIRECTED] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, LAB_BLACK},  // L* below zero clamps to 0
    '{8'd255, 8'd255, 8'd255, 1'b0, '0},         // white, index saturates
    '{8'd255, 8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd255, 1'b0, '0},
    '{8'd255, 8'd255, 8'd0,   1'b0, '0},
    '{8'd255, 8'd0,   8'd255, 1'b0, '0},
    '{8'd0,   8'd255, 8'd255, 1'b0, '0},
    '{8'd10,  8'd10,  8'd10,  1'b0, '0},         // top of linear segment
    '{8'd11,  8'd11,  8'd11,  1'b0, '0},         // first power-law code
    '{8'd10,  8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd11,  8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd10,  1'b0, '0},
    '{8'd1,   8'd1,   8'd1,   1'b0, '0},
    '{8'd128, 8'd128, 8'd128, 1'b0, '0},
    '{8'd254, 8'd254, 8'd254, 1'b0, '0},
    '{8'd170, 8'd85,  8'd170, 1'b0, '0},
    '{8'd85,  8'd170, 8'd85,  1'b0, '0},
    '{8'd255, 8'd255, 8'd254, 1'b0, '0},
    '{8'd0,   8'd0,   8'd1,   1'b0, '0},
    '{8'd1,   8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd1,   8'd0,   1'b0, '0},
    '{8'd254, 8'd1,   8'd128, 1'b0, '0}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [7:0]        red_i;
  logic [7:0]        green_i;
  logic [7:0]        blue_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [14:0]       lightness_o;
  logic signed [15:0] green_red_axis_o;
  logic signed [15:0] blue_yellow_axis_o;

  longint unsigned srgb_lin_tbl [256];         // linearized code, Q16
  longint          cbrt_tbl     [CUBE_DEPTH];  // cube root / linear tail, Q16

  pixel_row_t pixel_q [$];
  lab_t       lab_pending [$];
  int         px_accepted  = 0;
  int         mismatch_cnt = 0;

  rgb_to_cielab_converter_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .red_i              (red_i),
    .green_i            (green_i),
    .blue_i             (blue_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .lightness_o        (lightness_o),
    .green_red_axis_o   (green_red_axis_o),
    .blue_yellow_axis_o (blue_yellow_axis_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Row sum of the matrix to cube-root ROM index, saturating at the top entry
  function automatic longint unsigned xyz_index(input longint unsigned sum,
                                                input longint unsigned div);
    longint unsigned idx;
    idx = sum * 64'd4000 / div;
    if (idx >= CUBE_DEPTH) idx = CUBE_DEPTH - 1;
    return idx;
  endfunction

  function automatic longint clamp_q16(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Q16 to Q8, ties toward plus infinity
  function automatic longint round_q8(input longint v);
    if (v >= 0) return (v + 128) >>> 8;
    return -((-v + 127) >>> 8);
  endfunction

  // Bit-exact Lab of one pixel
  function automatic lab_t srgb_to_lab(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    longint unsigned lr, lg, lb, sx, sy, sz;
    longint vx, vy, vz, lq, aq, bq;
    lab_t res;
    lr = srgb_lin_tbl[r];
    lg = srgb_lin_tbl[g];
    lb = srgb_lin_tbl[b];
    sx = lr * 64'd412453 + lg * 64'd357580 + lb * 64'd180423;
    sy = lr * 64'd212671 + lg * 64'd715160 + lb * 64'd72169;
    sz = lr * 64'd19334  + lg * 64'd119193 + lb * 64'd950227;
    vx = cbrt_tbl[xyz_index(sx, X_DIV)];
    vy = cbrt_tbl[xyz_index(sy, Y_DIV)];
    vz = cbrt_tbl[xyz_index(sz, Z_DIV)];
    lq = clamp_q16(116 * vy - 16 * 65536, 0, LQ_MAX);
    aq = clamp_q16(500 * (vx - vy), -ABQ_MAX, ABQ_MAX);
    bq = clamp_q16(200 * (vy - vz), -ABQ_MAX, ABQ_MAX);
    res.l_star = 15'(round_q8(lq));
    res.a_star = 16'(round_q8(aq));
    res.b_star = 16'(round_q8(bq));
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // ROM contents for the model, built once at time zero
  initial begin : rom_build
    longint unsigned n, u, target, lo, hi, mid;
    for (int i = 0; i < 256; i++) begin
      if (i <= 10) begin
        srgb_lin_tbl[i] = (64'(i) * 64'd6553600 + 64'd164730) / 64'd329460;
      end else begin
        // t^2.4 as t^2 * t^0.4, fifth root by bisection in Q12
        n = 64'd1000 * 64'(i) + 64'd14025;
        u = ((n * n) << 24) / (64'd269025 * 64'd269025);
        target = u << 36;
        lo = 0;
        hi = 4096;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          if (mid * mid * mid * mid * mid <= target) lo = mid;
          else hi = mid - 1;
        end
        srgb_lin_tbl[i] = (u * lo + (64'd1 << 19)) >> 20;
      end
    end
    for (int k = 0; k < CUBE_DEPTH; k++) begin
      if (64'(k) * 64'd1000000 > 64'd8856 * 64'd4000) begin
        target = (64'(k) << 48) / 64'd4000;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          if (mid * mid * mid <= target) lo = mid;
          else hi = mid - 1;
        end
        cbrt_tbl[k] = longint'(lo);
      end else begin
        cbrt_tbl[k] = longint'(((64'd7787 * 64'd29 * 64'(k) + 64'd16000000) * 64'd65536)
                               / (64'd29000 * 64'd4000));
      end
    end
  end

  // Scoreboard: record each input transfer, check each output transfer
  always @(posedge clk_i) begin : lab_scoreboard
    lab_t want;
    lab_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (px_accepted < pixel_q.size() && pixel_q[px_accepted].known)
          want = pixel_q[px_accepted].golden;
        else
          want = srgb_to_lab(red_i, green_i, blue_i);
        lab_pending.insert(lab_pending.size(), want);
        px_accepted++;
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{lightness_o, green_red_axis_o, blue_yellow_axis_o};
        if (lab_pending.size() == 0) begin
          report_mismatch("output transfer with nothing pending, lightness",
                          int'(got.l_star), -1);
        end else begin
          want = lab_pending.pop_front();
          if (got.l_star != want.l_star)
            report_mismatch("lightness", int'(got.l_star), int'(want.l_star));
          if (got.a_star != want.a_star)
            report_mismatch("green_red_axis", int'(got.a_star), int'(want.a_star));
          if (got.b_star != want.b_star)
            report_mismatch("blue_yellow_axis", int'(got.b_star), int'(want.b_star));
        end
      end
    end
  end

  // Receiver: stall patterns in segments, plus one long hold-off
  initial begin : out_stall_gen
    stall_mode_t mode;
    int          seg_left;
    bit          held_off;
    out_stall_i = 1'b0;
    mode = STALL_NONE;
    seg_left = 0;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held_off && px_accepted >= HOLD_OFF_AT) begin
        // hold off long enough for the pipeline to fill and stall its input
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        for (int c = 0; c < HOLD_OFF_CYCLES; c++) @(posedge clk_i);
      end else begin
        if (seg_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(10, 150);
        end
        seg_left--;
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= (seg_left % 7 < 3);
        endcase
      end
    end
  end

  // Stimulus, reset and sender
  initial begin : pixel_source
    pixel_row_t row;
    int         px_sent;
    int         burst_left;
    int         gap_left;
    int         v;
    bit         done;
    in_valid_i = 1'b0;
    red_i      = '0;
    green_i    = '0;
    blue_i     = '0;
    rst_ni     = 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) pixel_q.insert(pixel_q.size(), CORNER_TBL[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      row = '0;
      case ($urandom_range(0, 9))
        0: begin  // saturated primaries and secondaries
          row.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          row.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          row.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        1: begin  // neutral gray
          v = $urandom_range(0, 255);
          row.red   = 8'(v);
          row.green = 8'(v);
          row.blue  = 8'(v);
        end
        2: begin  // around the gamma knee
          row.red   = 8'($urandom_range(0, 20));
          row.green = 8'($urandom_range(0, 20));
          row.blue  = 8'($urandom_range(0, 20));
        end
        3: begin  // near white, index saturation
          row.red   = 8'($urandom_range(235, 255));
          row.green = 8'($urandom_range(235, 255));
          row.blue  = 8'($urandom_range(235, 255));
        end
        default: begin
          row.red   = 8'($urandom_range(0, 255));
          row.green = 8'($urandom_range(0, 255));
          row.blue  = 8'($urandom_range(0, 255));
        end
      endcase
      pixel_q.insert(pixel_q.size(), row);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Bursts of random length with random gaps; hold payload while stalled
    px_sent = 0;
    burst_left = 0;
    gap_left = 0;
    done = 1'b0;
    while (!done) begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) px_sent++;
      if (!(in_valid_i && in_stall_o)) begin
        if (px_sent == pixel_q.size()) begin
          in_valid_i <= 1'b0;
          done = 1'b1;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          if (burst_left == 0) burst_left = $urandom_range(1, 64);
          in_valid_i <= 1'b1;
          red_i      <= pixel_q[px_sent].red;
          green_i    <= pixel_q[px_sent].green;
          blue_i     <= pixel_q[px_sent].blue;
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end

    // Drain: every transfer recorded and checked, then let the pipeline settle
    wait (px_accepted == pixel_q.size() && lab_pending.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit
  initial begin : run_limit
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
